[src/dtf_pkg.sv]
// Shared types and constants for the degenerate triangle filter.
// Used by dtf_area and degenerate_triangle_filter_core; no dependencies.
package dtf_pkg;

    localparam int COORD_W = 24;
    localparam int IDX_W   = 16;
    localparam int THR_W   = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int SQR_W   = 16;
    localparam int SUM_W   = 2 * SQR_W + 2;

    localparam logic CMD_VERTEX   = 1'b0;
    localparam logic CMD_TRIANGLE = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_KEEP   = 2'd0,
        VERDICT_REPEAT = 2'd1,
        VERDICT_SMALL  = 2'd2
    } verdict_t;

    // x in the lowest bits, matching the request packing
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vtx_t;

    typedef struct packed {
        logic done;
        logic below;
    } area_res_t;

endpackage

[src/dtf_area.sv]
// Pipelined squared cross-product magnitude test against a threshold.
// Depends on dtf_pkg; six register stages from start to res.done.
module dtf_area
    import dtf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  vtx_t              va,
    input  vtx_t              vb,
    input  vtx_t              vc,
    input  logic [THR_W-1:0]  thr,
    output area_res_t         res
);

    localparam int STAGES = 6;

    logic [STAGES-1:0]         vld_reg;
    logic signed [DIFF_W-1:0]  ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CROSS_W-1:0] c0_reg, c1_reg, c2_reg;
    logic [MAG_W-1:0]          m0_reg, m1_reg, m2_reg;
    logic [2*SQR_W-1:0]        q0_reg, q1_reg, q2_reg;
    logic                      big_reg;
    logic                      below_reg;
    logic [SUM_W-1:0]          sum;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [CROSS_W-1:0] c);
        logic signed [CROSS_W-1:0] n;
        begin
            n = c[CROSS_W-1] ? -c : c;
            mag_of = n[MAG_W-1:0];
        end
    endfunction

    assign sum = SUM_W'(q0_reg) + SUM_W'(q1_reg) + SUM_W'(q2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg <= DIFF_W'(vb.x) - DIFF_W'(va.x);
        uy_reg <= DIFF_W'(vb.y) - DIFF_W'(va.y);
        uz_reg <= DIFF_W'(vb.z) - DIFF_W'(va.z);
        vx_reg <= DIFF_W'(vc.x) - DIFF_W'(va.x);
        vy_reg <= DIFF_W'(vc.y) - DIFF_W'(va.y);
        vz_reg <= DIFF_W'(vc.z) - DIFF_W'(va.z);

        p0_reg <= uy_reg * vz_reg;
        p1_reg <= uz_reg * vy_reg;
        p2_reg <= uz_reg * vx_reg;
        p3_reg <= ux_reg * vz_reg;
        p4_reg <= ux_reg * vy_reg;
        p5_reg <= uy_reg * vx_reg;

        c0_reg <= CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
        c1_reg <= CROSS_W'(p2_reg) - CROSS_W'(p3_reg);
        c2_reg <= CROSS_W'(p4_reg) - CROSS_W'(p5_reg);

        m0_reg <= mag_of(c0_reg);
        m1_reg <= mag_of(c1_reg);
        m2_reg <= mag_of(c2_reg);

        q0_reg  <= m0_reg[SQR_W-1:0] * m0_reg[SQR_W-1:0];
        q1_reg  <= m1_reg[SQR_W-1:0] * m1_reg[SQR_W-1:0];
        q2_reg  <= m2_reg[SQR_W-1:0] * m2_reg[SQR_W-1:0];
        big_reg <= (|m0_reg[MAG_W-1:SQR_W]) | (|m1_reg[MAG_W-1:SQR_W])
                 | (|m2_reg[MAG_W-1:SQR_W]);

        below_reg <= !big_reg && (sum < SUM_W'(thr));
    end

    assign res.done  = vld_reg[STAGES-1];
    assign res.below = below_reg;

endmodule

[src/degenerate_triangle_filter_core.sv]
// Degenerate triangle filter, top level: vertex store, sequencer and output stage.
// Depends on dtf_pkg and dtf_area.
//
// A vertex request (tuser 0) writes one store slot. A triangle request (tuser 1)
// has its three corners read one after another from the single-port vertex store,
// then passes the six-stage area pipeline and the verdict stage. One triangle is in
// work at a time; the result register lets the next request enter while it waits
// to be taken. Slots at or beyond the store depth read as the origin and ignore
// writes. The threshold is written through cfg_we / cfg_wdata and resets to 1.
module degenerate_triangle_filter_core
    import dtf_pkg::*;
#(
    parameter int VERTEX_DEPTH = 65536
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [135:0]  s_axis_tdata,
    // cmd
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_a, out_b, out_c, verdict, zero fill
    output logic [55:0]   m_axis_tdata,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata
);

    localparam int SLOTS = (VERTEX_DEPTH < 65536) ? VERTEX_DEPTH : 65536;
    localparam int AW    = $clog2(SLOTS);
    localparam logic [IDX_W:0] SLOTS_W = (IDX_W+1)'(SLOTS);

    typedef enum logic [2:0] {
        IDLE,
        RD_B,
        RD_C,
        LD_C,
        CALC,
        DONE
    } state_t;

    state_t            state_reg, state_next;
    vtx_t              mem [SLOTS];
    vtx_t              rdata_reg;
    vtx_t              va_reg, vb_reg, vc;
    logic [IDX_W-1:0]  a_reg, b_reg, c_reg;
    logic              dup_reg;
    logic              below_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              m_tvalid_reg;
    logic [IDX_W-1:0]  out_a_reg, out_b_reg, out_c_reg;
    verdict_t          verdict_reg;
    verdict_t          verdict_next;
    area_res_t         area_res;

    logic [IDX_W-1:0]  in_index, in_a, in_b, in_c;
    vtx_t              in_vtx;
    logic              accept, wr_en, rd_en;
    logic [IDX_W-1:0]  rd_index;
    logic              a_ok, b_ok, c_ok, in_ok;

    assign in_index = s_axis_tdata[15:0];
    assign in_vtx   = vtx_t'(s_axis_tdata[87:16]);
    assign in_a     = s_axis_tdata[103:88];
    assign in_b     = s_axis_tdata[119:104];
    assign in_c     = s_axis_tdata[135:120];

    assign s_axis_tready = (state_reg == IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_ok = {1'b0, in_index} < SLOTS_W;
    assign a_ok  = {1'b0, a_reg} < SLOTS_W;
    assign b_ok  = {1'b0, b_reg} < SLOTS_W;
    assign c_ok  = {1'b0, c_reg} < SLOTS_W;

    assign wr_en = accept && (s_axis_tuser[0] == CMD_VERTEX) && in_ok;

    always_comb
    begin
        rd_en    = 1'b0;
        rd_index = in_a;
        unique case (state_reg)
            IDLE:
            begin
                rd_en    = accept && (s_axis_tuser[0] == CMD_TRIANGLE);
                rd_index = in_a;
            end
            RD_B:
            begin
                rd_en    = 1'b1;
                rd_index = b_reg;
            end
            RD_C:
            begin
                rd_en    = 1'b1;
                rd_index = c_reg;
            end
            default:
            begin
                rd_en    = 1'b0;
                rd_index = c_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[in_index[AW-1:0]] <= in_vtx;
        end
        else if (rd_en)
        begin
            rdata_reg <= mem[rd_index[AW-1:0]];
        end
    end

    assign vc = c_ok ? rdata_reg : '0;

    dtf_area u_area (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == LD_C),
        .va    (va_reg),
        .vb    (vb_reg),
        .vc    (vc),
        .thr   (thr_reg),
        .res   (area_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        priority if (dup_reg)
        begin
            verdict_next = VERDICT_REPEAT;
        end
        else if (below_reg)
        begin
            verdict_next = VERDICT_SMALL;
        end
        else
        begin
            verdict_next = VERDICT_KEEP;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (accept && (s_axis_tuser[0] == CMD_TRIANGLE))
                begin
                    state_next = RD_B;
                end
            end
            RD_B: state_next = RD_C;
            RD_C: state_next = LD_C;
            LD_C: state_next = CALC;
            CALC:
            begin
                if (area_res.done)
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == DONE) && (!m_tvalid_reg || m_axis_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (s_axis_tuser[0] == CMD_TRIANGLE))
        begin
            a_reg   <= in_a;
            b_reg   <= in_b;
            c_reg   <= in_c;
            dup_reg <= (in_a == in_b) || (in_b == in_c) || (in_a == in_c);
        end
        if (state_reg == RD_B)
        begin
            va_reg <= a_ok ? rdata_reg : '0;
        end
        if (state_reg == RD_C)
        begin
            vb_reg <= b_ok ? rdata_reg : '0;
        end
        if ((state_reg == CALC) && area_res.done)
        begin
            below_reg <= area_res.below;
        end
        if ((state_reg == DONE) && (!m_tvalid_reg || m_axis_tready))
        begin
            out_a_reg   <= a_reg;
            out_b_reg   <= b_reg;
            out_c_reg   <= c_reg;
            verdict_reg <= verdict_next;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {6'b0, verdict_reg, out_c_reg, out_b_reg, out_a_reg};

`ifndef SYNTHESIS
    a_tri_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_axis_tuser[0] == CMD_TRIANGLE)) |=> (state_reg == RD_B))
        else $error("triangle request did not start the corner reads");

    a_area_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        area_res.done |-> (state_reg == CALC))
        else $error("area result outside the wait state");

    a_repeat_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (verdict_reg == VERDICT_REPEAT)) |->
        ((out_a_reg == out_b_reg) || (out_b_reg == out_c_reg) || (out_a_reg == out_c_reg)))
        else $error("repeat verdict without a repeated corner");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for degenerate_triangle_filter_core: random and directed vertex and triangle
// requests, with the verdicts checked against a scoreboard that keeps its own vertex store.
// Depends on dtf_pkg and the filter RTL only.
module testbench
    import dtf_pkg::*;
();

    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        verdict_t    verdict;
    } triangle_result_t;

    class verdict_board;
        vtx_t               vertex_copy [0:65535];
        logic [31:0]        threshold;
        triangle_result_t   expected_verdicts [$];
        int                 failures;

        function new();
            threshold = 32'd1;
            failures  = 0;
        endfunction

        function void set_threshold(logic [31:0] value);
            threshold = value;
        endfunction

        function verdict_t classify_triangle(logic [15:0] ia, logic [15:0] ib,
                                             logic [15:0] ic);
            vtx_t pa;
            vtx_t pb;
            vtx_t pc;
            longint ux, uy, uz, vx, vy, vz;
            longint cross_term [3];
            longint mag;
            longint unsigned sum;
            if (ia == ib || ib == ic || ia == ic)
                return VERDICT_REPEAT;
            pa = vertex_copy[ia];
            pb = vertex_copy[ib];
            pc = vertex_copy[ic];
            ux = longint'($signed(pb.x)) - longint'($signed(pa.x));
            uy = longint'($signed(pb.y)) - longint'($signed(pa.y));
            uz = longint'($signed(pb.z)) - longint'($signed(pa.z));
            vx = longint'($signed(pc.x)) - longint'($signed(pa.x));
            vy = longint'($signed(pc.y)) - longint'($signed(pa.y));
            vz = longint'($signed(pc.z)) - longint'($signed(pa.z));
            cross_term[0] = uy * vz - uz * vy;
            cross_term[1] = uz * vx - ux * vz;
            cross_term[2] = ux * vy - uy * vx;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag = (cross_term[i] < 0) ? -cross_term[i] : cross_term[i];
                if (mag >= 65536)
                    return VERDICT_KEEP;
                sum += longint'(mag * mag);
            end
            return (sum < longint'(threshold)) ? VERDICT_SMALL : VERDICT_KEEP;
        endfunction

        function void note_request(logic cmd, logic [135:0] data);
            triangle_result_t want;
            if (cmd == CMD_VERTEX)
            begin
                vertex_copy[data[15:0]] = data[87:16];
            end
            else
            begin
                want.a       = data[103:88];
                want.b       = data[119:104];
                want.c       = data[135:120];
                want.verdict = classify_triangle(want.a, want.b, want.c);
                expected_verdicts.insert(expected_verdicts.size(), want);
            end
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch in %s: expected %0h, got %0h", field, want, got);
            end
        endfunction

        function void check_result(logic [55:0] data);
            triangle_result_t want;
            if (expected_verdicts.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result %h with no request waiting", data);
                return;
            end
            want = expected_verdicts.pop_front();
            compare("out_a", want.a, data[15:0]);
            compare("out_b", want.b, data[31:16]);
            compare("out_c", want.c, data[47:32]);
            compare("verdict", 16'(want.verdict), 16'(data[49:48]));
            compare("fill", 16'd0, 16'(data[55:50]));
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [135:0]  s_axis_tdata = '0;
    logic [0:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [55:0]   m_axis_tdata;
    logic          cfg_we = 1'b0;
    logic [31:0]   cfg_wdata = '0;

    verdict_board  board;
    logic [15:0]   written_slots [$];
    int            items_sent = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_asked = 0;
    int            hold_served = 0;
    int            hold_left = 0;
    int            cycle_count = 0;

    degenerate_triangle_filter_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_request(s_axis_tuser[0], s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [135:0] pack_request(logic [15:0] slot, logic [23:0] x,
                                                  logic [23:0] y, logic [23:0] z,
                                                  logic [15:0] a, logic [15:0] b,
                                                  logic [15:0] c);
        return {c, b, a, z, y, x, slot};
    endfunction

    function automatic logic [15:0] pick_slot();
        return ($urandom_range(3) == 0) ? 16'($urandom_range(15)) : 16'($urandom);
    endfunction

    function automatic logic [15:0] pool_slot();
        return written_slots[$urandom_range(written_slots.size() - 1)];
    endfunction

    function automatic int offset(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    task automatic send_request(logic cmd, logic [135:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic put_vertex(logic [15:0] slot, logic [23:0] x, logic [23:0] y,
                              logic [23:0] z);
        send_request(CMD_VERTEX, pack_request(slot, x, y, z,
                                              16'($urandom), 16'($urandom),
                                              16'($urandom)));
        written_slots.insert(written_slots.size(), slot);
    endtask

    task automatic put_triangle(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        send_request(CMD_TRIANGLE, pack_request(16'($urandom), 24'($urandom),
                                                24'($urandom), 24'($urandom),
                                                a, b, c));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [31:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_threshold(value);
    endtask

    task automatic directed_triangles();
        put_triangle(16'd7, 16'd7, 16'd9);
        put_triangle(16'd9, 16'd11, 16'd11);
        put_triangle(16'hFFFF, 16'd0, 16'hFFFF);
        put_triangle(16'd12, 16'd12, 16'd12);
        put_triangle(16'd0, 16'hFFFF, 16'd1);
        put_triangle(16'd1, 16'hFFFF, 16'd0);
        put_triangle(16'd0, 16'd2, 16'd3);
        put_triangle(16'd0, 16'd2, 16'd4);
        put_triangle(16'd0, 16'd2, 16'd5);
        put_triangle(16'd0, 16'd2, 16'd6);
    endtask

    task automatic shaped_triangle();
        logic [15:0] s0, s1, s2;
        int px [3];
        int py [3];
        int pz [3];
        int shape, spread, dx, dy, dz, k;
        s0 = pick_slot();
        do s1 = pick_slot(); while (s1 == s0);
        do s2 = pick_slot(); while (s2 == s0 || s2 == s1);
        shape = $urandom_range(3);
        px[0] = offset(1 << 20);
        py[0] = offset(1 << 20);
        pz[0] = offset(1 << 20);
        case (shape)
            0:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    px[i] = $urandom;
                    py[i] = $urandom;
                    pz[i] = $urandom;
                end
            end
            1:
            begin
                spread = 1 << (2 * $urandom_range(4));
                for (int i = 1; i < 3; i++)
                begin
                    px[i] = px[0] + offset(spread);
                    py[i] = py[0] + offset(spread);
                    pz[i] = pz[0] + offset(spread);
                end
            end
            default:
            begin
                dx = offset(1024);
                dy = offset(1024);
                dz = offset(1024);
                k  = int'($urandom_range(6)) - 3;
                px[1] = px[0] + dx;
                py[1] = py[0] + dy;
                pz[1] = pz[0] + dz;
                px[2] = px[0] + k * dx;
                py[2] = py[0] + k * dy;
                pz[2] = pz[0] + k * dz + ((shape == 3) ? offset(1) : 0);
            end
        endcase
        put_vertex(s0, 24'(px[0]), 24'(py[0]), 24'(pz[0]));
        put_vertex(s1, 24'(px[1]), 24'(py[1]), 24'(pz[1]));
        put_vertex(s2, 24'(px[2]), 24'(py[2]), 24'(pz[2]));
        put_triangle(s0, s1, s2);
    endtask

    task automatic random_sequence();
        int pick;
        logic [15:0] a, b;
        pick = $urandom_range(99);
        a = 16'($urandom);
        b = 16'($urandom);
        if (pick < 70)
            shaped_triangle();
        else if (pick < 85)
            put_triangle(pool_slot(), pool_slot(), pool_slot());
        else if (pick < 95)
        begin
            case ($urandom_range(2))
                0: put_triangle(a, a, b);
                1: put_triangle(b, a, a);
                default: put_triangle(a, b, a);
            endcase
        end
        else
            put_vertex(pick_slot(), 24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic run_phase(int budget, int idle_pct, int stall_pct);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + budget;
        while (items_sent < target)
            random_sequence();
    endtask

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_vertex(16'd0, 24'sd0, 24'sd0, 24'sd0);
        put_vertex(16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        put_vertex(16'd1, 24'h800000, 24'h800000, 24'h7FFFFF);
        put_vertex(16'd2, 24'sd4096, 24'sd0, 24'sd0);
        put_vertex(16'd3, 24'sd8192, 24'sd0, 24'sd0);
        put_vertex(16'd4, 24'sd0, 24'sd1, 24'sd0);
        put_vertex(16'd5, 24'sd0, 24'sd16, 24'sd0);
        put_vertex(16'd6, 24'sd0, 24'sd15, 24'sd0);
        directed_triangles();
        run_phase(260, 0, 0);

        write_threshold(32'd0);
        directed_triangles();
        run_phase(300, 51, 0);

        write_threshold(32'hFFFF_FFFF);
        hold_asked++;
        directed_triangles();
        run_phase(300, 0, 51);

        write_threshold(32'd1);
        run_phase(320, 15, 15);

        write_threshold($urandom_range(1 << 24));
        run_phase(320, 0, 0);

        write_threshold($urandom);
        run_phase(320, 51, 0);

        wait_drained();
        if (board.failures == 0 && board.expected_verdicts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[sim.f]
src/dtf_pkg.sv
src/dtf_area.sv
src/degenerate_triangle_filter_core.sv
tb/testbench.sv
